>>> rtl/periodic_task_due_scheduler_core_assert.svh
// Assertion macros used by the scheduler core.
`ifndef PERIODIC_TASK_DUE_SCHEDULER_CORE_ASSERT_SVH
`define PERIODIC_TASK_DUE_SCHEDULER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTDS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PTDS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

>>> rtl/ptds_pkg.sv
// Types and constants shared by the periodic task scheduler modules.
`default_nettype none

package ptds_pkg;

    localparam int TIME_W    = 32;
    localparam int IDX_OUT_W = 3;

    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_RUN      = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/ptds_cell.sv
// One task slot of the scheduler chain: period, last-run time and scan token.
`default_nettype none

module ptds_cell import ptds_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic              wr_en,
    input  wire logic [TIME_W-1:0] wr_period,
    input  wire logic [TIME_W-1:0] wr_time,
    input  wire logic [TIME_W-1:0] run_time,
    input  wire logic              tok_in,
    output logic                   tok,
    output logic                   due
);

    logic [TIME_W-1:0] period_reg;
    logic [TIME_W-1:0] last_run_reg;
    logic              tok_reg;
    logic              tok_next;
    logic [TIME_W-1:0] elapsed;

    assign elapsed = run_time - last_run_reg;
    assign due     = tok_reg && (elapsed >= period_reg);
    assign tok     = tok_reg;

    always_comb begin
        tok_next = tok_reg;
        if (ctrl.clear) begin
            tok_next = 1'b0;
        end else if (ctrl.load || ctrl.step) begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            period_reg   <= wr_period;
            last_run_reg <= wr_time;
        end else if (ctrl.step && due) begin
            last_run_reg <= run_time;
        end
    end

endmodule

`default_nettype wire

>>> rtl/periodic_task_due_scheduler_core.sv
// Top level of the periodic task scheduler: control, result staging and the cell chain.
`default_nettype none
`include "periodic_task_due_scheduler_core_assert.svh"

// The block keeps up to MAX_TASKS periodic tasks in a chain of cells, one task per cell.
// A register request (tuser 0) appends a task. Its one result is held in a staging
// register and moves into the output register once the output register has room.
// A run request (tuser 1) passes a scan token along the chain, one registered task per
// cycle while no due result waits for room in the output register; the pass ends after
// the last registered task. Each due task gives a fired result; the last result of every
// request carries tlast. A new request is taken once the previous one has placed its final
// result in the output register.
module periodic_task_due_scheduler_core import ptds_pkg::*; #(
    parameter int MAX_TASKS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // now_time [31:0], period [63:32]
    input  wire logic        s_tuser,   // mode [0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // status [0], fired [1], task_index [4:2], zero [7:5]
    output logic             m_tlast
);

    localparam int CW = $clog2(MAX_TASKS + 1);

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              hold_valid_reg, hold_valid_next;
    logic              hold_status_reg, hold_status_next;
    logic              hold_fired_reg, hold_fired_next;
    logic [CW-1:0]     hold_index_reg, hold_index_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_status_reg, out_status_next;
    logic                 out_fired_reg, out_fired_next;
    logic [IDX_OUT_W-1:0] out_index_reg, out_index_next;
    logic                 out_last_reg, out_last_next;

    cell_ctrl_t             ctrl;
    logic                   wr_req;
    logic [MAX_TASKS-1:0]   wr_sel;
    logic [MAX_TASKS-1:0]   tok_vec;
    logic [MAX_TASKS-1:0]   due_vec;
    logic                   due_any;
    logic                   out_free;
    logic                   push;
    logic                   push_last;
    logic                   accept;
    logic                   at_end;
    logic [CW+IDX_OUT_W-1:0] hold_ext;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign at_end   = (idx_reg == count_reg);
    assign due_any  = |due_vec;
    assign hold_ext = {{IDX_OUT_W{1'b0}}, hold_index_reg};
    assign wr_req   = accept && (s_tuser == MODE_REGISTER) && (count_reg < CW'(MAX_TASKS));

    for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
        logic tok_in;
        assign wr_sel[i] = wr_req && (count_reg == CW'(i));
        if (i == 0) begin : g_head
            assign tok_in = ctrl.load;
        end else begin : g_link
            assign tok_in = tok_vec[i-1];
        end
        ptds_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .wr_en     (wr_sel[i]),
            .wr_period (s_tdata[63:32]),
            .wr_time   (s_tdata[31:0]),
            .run_time  (now_reg),
            .tok_in    (tok_in),
            .tok       (tok_vec[i]),
            .due       (due_vec[i])
        );
    end

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        now_next         = now_reg;
        hold_valid_next  = hold_valid_reg;
        hold_status_next = hold_status_reg;
        hold_fired_next  = hold_fired_reg;
        hold_index_next  = hold_index_reg;
        ctrl             = '0;
        push             = 1'b0;
        push_last        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    hold_fired_next = 1'b0;
                    if (s_tuser == MODE_RUN) begin
                        ctrl.load        = 1'b1;
                        idx_next         = '0;
                        now_next         = s_tdata[31:0];
                        hold_valid_next  = 1'b0;
                        hold_status_next = STATUS_OK;
                        hold_index_next  = '0;
                        state_next       = ST_SCAN;
                    end else begin
                        hold_valid_next = 1'b1;
                        if (count_reg < CW'(MAX_TASKS)) begin
                            hold_status_next = STATUS_OK;
                            hold_index_next  = count_reg;
                            count_next       = count_reg + CW'(1);
                        end else begin
                            hold_status_next = STATUS_FULL;
                            hold_index_next  = '0;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (at_end) begin
                    ctrl.clear = 1'b1;
                    state_next = ST_DONE;
                end else if (!(due_any && hold_valid_reg && !out_free)) begin
                    ctrl.step = 1'b1;
                    idx_next  = idx_reg + CW'(1);
                    if (due_any) begin
                        push            = hold_valid_reg;
                        hold_valid_next = 1'b1;
                        hold_fired_next = 1'b1;
                        hold_index_next = idx_reg;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_fired_next  = out_fired_reg;
        out_index_next  = out_index_reg;
        out_last_next   = out_last_reg;
        if (push) begin
            out_valid_next  = 1'b1;
            out_status_next = hold_status_reg;
            out_fired_next  = hold_fired_reg;
            out_index_next  = hold_ext[IDX_OUT_W-1:0];
            out_last_next   = push_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg         <= now_next;
        hold_status_reg <= hold_status_next;
        hold_fired_reg  <= hold_fired_next;
        hold_index_reg  <= hold_index_next;
        out_status_reg  <= out_status_next;
        out_fired_reg   <= out_fired_next;
        out_index_reg   <= out_index_next;
        out_last_reg    <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_index_reg, out_fired_reg, out_status_reg};

    `PTDS_ASSERT_NOW(a_token_single, aclk, aresetn, 1'b1, $onehot0(tok_vec))
    `PTDS_ASSERT_NOW(a_token_present, aclk, aresetn, (state_reg == ST_SCAN) && !at_end,
                     $onehot(tok_vec))
    `PTDS_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(MAX_TASKS))
    `PTDS_ASSERT_NEXT(a_scan_not_last, aclk, aresetn, (state_reg == ST_SCAN) && push,
                      m_tvalid && !m_tlast && out_fired_reg)

endmodule

`default_nettype wire
